FILE: design/qalu_pkg.sv
`default_nettype none
package qalu_pkg;

	localparam logic [2:0] OP_ADD  = 3'd0;
	localparam logic [2:0] OP_NEG  = 3'd1;
	localparam logic [2:0] OP_MUL  = 3'd2;
	localparam logic [2:0] OP_CONJ = 3'd3;
	localparam logic [2:0] OP_NORM = 3'd4;
	localparam logic [2:0] OP_INV  = 3'd5;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SAT  = 2'd1;
	localparam logic [1:0] ST_DIVZ = 2'd2;

	// quotient bits of the inverse divider, one per step stage
	localparam int NSTEP = 33;
	// root bits of the square root
	localparam int NROOT = 32;

	typedef struct packed {
		logic [2:0]         op;
		logic signed [31:0] a_w;
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_w;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] r_w;
		logic signed [31:0] r_x;
		logic signed [31:0] r_y;
		logic signed [31:0] r_z;
		logic [31:0]        magnitude;
		logic [1:0]         status;
	} res_t;

	typedef struct packed {
		logic [2:0]        op;
		logic              carry;
		logic              zero;
		logic [3:0]        neg;
		logic [3:0][31:0]  pass;
		logic              sat;
		logic [64:0]       dvsr;
		logic [63:0]       rad;
		logic [3:0][64:0]  drem;
		logic [3:0][32:0]  quo;
		logic [3:0]        m0;
		logic [33:0]       srem;
		logic [31:0]       root;
	} iter_t;

	// {flag, value}
	function automatic logic [32:0] sat32(input logic signed [49:0] v);
		logic [32:0] r;
		if (v > 50'sd2147483647) begin
			r = {1'b1, 32'h7FFF_FFFF};
		end else if (v < -50'sd2147483648) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage
`default_nettype wire

FILE: design/qalu_front.sv
`default_nettype none
module qalu_front (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   vld,
	input  wire qalu_pkg::cmd_t   cmd,
	output logic                  out_vld,
	output qalu_pkg::iter_t       out_it
);

	logic             v_s1, v_s2, v_s3, v_s4;
	qalu_pkg::cmd_t   cmd_s1;

	logic signed [31:0] a_c [4];
	logic signed [31:0] b_c [4];
	logic signed [63:0] prod_c [4][4];
	logic [31:0]        mag_c [4];
	logic [63:0]        sq_c [4];
	logic [3:0][31:0]   pass_c;
	logic               sat_c;
	logic [3:0]         neg_c;
	logic [32:0]        st_c;

	logic signed [63:0] prod_s2 [4][4];
	logic [63:0]        sq_s2 [4];
	logic [31:0]        mag_s2 [4];
	logic [2:0]         op_s2;
	logic [3:0][31:0]   pass_s2;
	logic               sat_s2;
	logic [3:0]         neg_s2;

	logic signed [65:0] ham_s3 [4];
	logic [64:0]        sum_s3;
	logic [31:0]        mag_s3 [4];
	logic [2:0]         op_s3;
	logic [3:0][31:0]   pass_s3;
	logic               sat_s3;
	logic [3:0]         neg_s3;

	qalu_pkg::iter_t    it_c, it_s4;
	logic signed [65:0] rnd_c [4];
	logic [32:0]        hs_c [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= vld;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		cmd_s1 <= cmd;
	end

	// stage 2: products, squares, simple ops
	always_comb begin
		a_c[0] = cmd_s1.a_w; a_c[1] = cmd_s1.a_x; a_c[2] = cmd_s1.a_y; a_c[3] = cmd_s1.a_z;
		b_c[0] = cmd_s1.b_w; b_c[1] = cmd_s1.b_x; b_c[2] = cmd_s1.b_y; b_c[3] = cmd_s1.b_z;
		for (int i = 0; i < 4; i++) begin
			for (int j = 0; j < 4; j++) begin
				prod_c[i][j] = 64'(a_c[i]) * 64'(b_c[j]);
			end
			mag_c[i] = a_c[i][31] ? 32'(-a_c[i]) : a_c[i];
			sq_c[i]  = 64'(mag_c[i]) * 64'(mag_c[i]);
		end
		neg_c[0] = a_c[0][31];
		for (int i = 1; i < 4; i++) begin
			neg_c[i] = !a_c[i][31] && (a_c[i] != 32'sd0);
		end
		sat_c  = 1'b0;
		pass_c = '0;
		for (int i = 0; i < 4; i++) begin
			unique case (cmd_s1.op)
				qalu_pkg::OP_ADD: st_c = qalu_pkg::sat32(50'(a_c[i]) + 50'(b_c[i]));
				qalu_pkg::OP_NEG: st_c = qalu_pkg::sat32(-50'(a_c[i]));
				qalu_pkg::OP_CONJ: begin
					if (i == 0) st_c = {1'b0, a_c[i]};
					else st_c = qalu_pkg::sat32(-50'(a_c[i]));
				end
				default: st_c = '0;
			endcase
			pass_c[i] = st_c[31:0];
			sat_c     = sat_c | st_c[32];
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= prod_c;
		sq_s2   <= sq_c;
		mag_s2  <= mag_c;
		op_s2   <= cmd_s1.op;
		pass_s2 <= pass_c;
		sat_s2  <= sat_c;
		neg_s2  <= neg_c;
	end

	// stage 3: Hamilton sums in Q34.32, sum of squares
	always_ff @(posedge clk) begin
		ham_s3[0] <= 66'(prod_s2[0][0]) - 66'(prod_s2[1][1])
			- 66'(prod_s2[2][2]) - 66'(prod_s2[3][3]);
		ham_s3[1] <= 66'(prod_s2[0][1]) + 66'(prod_s2[1][0])
			+ 66'(prod_s2[2][3]) - 66'(prod_s2[3][2]);
		ham_s3[2] <= 66'(prod_s2[0][2]) - 66'(prod_s2[1][3])
			+ 66'(prod_s2[2][0]) + 66'(prod_s2[3][1]);
		ham_s3[3] <= 66'(prod_s2[0][3]) + 66'(prod_s2[1][2])
			- 66'(prod_s2[2][1]) + 66'(prod_s2[3][0]);
		sum_s3  <= 65'(sq_s2[0]) + 65'(sq_s2[1]) + 65'(sq_s2[2]) + 65'(sq_s2[3]);
		mag_s3  <= mag_s2;
		op_s3   <= op_s2;
		pass_s3 <= pass_s2;
		sat_s3  <= sat_s2;
		neg_s3  <= neg_s2;
	end

	// stage 4: round product, seed root and divider
	always_comb begin
		it_c       = '0;
		it_c.op    = op_s3;
		it_c.carry = sum_s3[64];
		it_c.zero  = (sum_s3 == 65'd0);
		it_c.neg   = neg_s3;
		it_c.pass  = pass_s3;
		it_c.sat   = sat_s3;
		it_c.dvsr  = sum_s3;
		it_c.rad   = sum_s3[63:0];
		for (int i = 0; i < 4; i++) begin
			rnd_c[i] = ham_s3[i] + 66'sd32768;
			hs_c[i]  = qalu_pkg::sat32(rnd_c[i][65:16]);
			it_c.drem[i] = {34'd0, mag_s3[i][31:1]};
			it_c.m0[i]   = mag_s3[i][0];
		end
		if (op_s3 == qalu_pkg::OP_MUL) begin
			it_c.sat = hs_c[0][32] | hs_c[1][32] | hs_c[2][32] | hs_c[3][32];
			for (int i = 0; i < 4; i++) begin
				it_c.pass[i] = hs_c[i][31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		it_s4 <= it_c;
	end

	assign out_vld = v_s4;
	assign out_it  = it_s4;

endmodule
`default_nettype wire

FILE: design/qalu_step.sv
`default_nettype none
module qalu_step #(
	parameter int STEP = 0
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   vld,
	input  wire qalu_pkg::iter_t  it,
	output logic                  out_vld,
	output qalu_pkg::iter_t       out_it
);

	logic             vld_s1;
	qalu_pkg::iter_t  it_c, it_s1;
	logic [65:0]      sh_c [4];

	// one restoring divide step per lane
	always_comb begin
		it_c = it;
		for (int i = 0; i < 4; i++) begin
			sh_c[i] = {it.drem[i], (STEP == 0) ? it.m0[i] : 1'b0};
			if (sh_c[i] >= {1'b0, it.dvsr}) begin
				it_c.drem[i] = 65'(sh_c[i] - {1'b0, it.dvsr});
				it_c.quo[i]  = {it.quo[i][31:0], 1'b1};
			end else begin
				it_c.drem[i] = sh_c[i][64:0];
				it_c.quo[i]  = {it.quo[i][31:0], 1'b0};
			end
		end
	end

	// one square root step
	generate
		if (STEP < qalu_pkg::NROOT) begin : g_root
			localparam int HI = 63 - 2 * STEP;
			logic [35:0] sr_c, tr_c;
			logic [33:0] srem_c;
			logic [31:0] root_c;
			always_comb begin
				sr_c = {it.srem, it.rad[HI -: 2]};
				tr_c = {2'b00, it.root, 2'b01};
				if (sr_c >= tr_c) begin
					srem_c = 34'(sr_c - tr_c);
					root_c = {it.root[30:0], 1'b1};
				end else begin
					srem_c = sr_c[33:0];
					root_c = {it.root[30:0], 1'b0};
				end
			end
			always_ff @(posedge clk) begin
				it_s1 <= '{op: it_c.op, carry: it_c.carry, zero: it_c.zero, neg: it_c.neg,
					pass: it_c.pass, sat: it_c.sat, dvsr: it_c.dvsr, rad: it_c.rad,
					drem: it_c.drem, quo: it_c.quo, m0: it_c.m0, srem: srem_c,
					root: root_c};
			end
		end else begin : g_noroot
			always_ff @(posedge clk) begin
				it_s1 <= it_c;
			end
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld;
		end
	end

	assign out_vld = vld_s1;
	assign out_it  = it_s1;

endmodule
`default_nettype wire

FILE: design/qalu_back.sv
`default_nettype none
module qalu_back (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   vld,
	input  wire qalu_pkg::iter_t  it,
	output logic                  done,
	output qalu_pkg::res_t        res
);

	logic              done_s1;
	qalu_pkg::res_t    res_c, res_s1;
	logic [33:0]       q_c [4];
	logic [3:0][31:0]  inv_c;
	logic              isat_c;

	always_comb begin
		isat_c = 1'b0;
		for (int i = 0; i < 4; i++) begin
			q_c[i] = {1'b0, it.quo[i]}
				+ 34'(({it.drem[i], 1'b0} >= {1'b0, it.dvsr}) ? 1 : 0);
			if (it.neg[i]) begin
				if (q_c[i] > 34'd2147483648) begin
					inv_c[i] = 32'h8000_0000;
					isat_c   = 1'b1;
				end else begin
					inv_c[i] = ~q_c[i][31:0] + 32'd1;
				end
			end else begin
				if (q_c[i] > 34'd2147483647) begin
					inv_c[i] = 32'h7FFF_FFFF;
					isat_c   = 1'b1;
				end else begin
					inv_c[i] = q_c[i][31:0];
				end
			end
		end

		res_c = '0;
		unique case (it.op)
			qalu_pkg::OP_ADD, qalu_pkg::OP_NEG, qalu_pkg::OP_MUL, qalu_pkg::OP_CONJ: begin
				res_c.r_w    = it.pass[0];
				res_c.r_x    = it.pass[1];
				res_c.r_y    = it.pass[2];
				res_c.r_z    = it.pass[3];
				res_c.status = it.sat ? qalu_pkg::ST_SAT : qalu_pkg::ST_OK;
			end
			qalu_pkg::OP_NORM: begin
				res_c.magnitude = it.carry ? 32'hFFFF_FFFF : it.root;
				res_c.status    = it.carry ? qalu_pkg::ST_SAT : qalu_pkg::ST_OK;
			end
			qalu_pkg::OP_INV: begin
				if (it.zero) begin
					res_c.status = qalu_pkg::ST_DIVZ;
				end else begin
					res_c.r_w    = inv_c[0];
					res_c.r_x    = inv_c[1];
					res_c.r_y    = inv_c[2];
					res_c.r_z    = inv_c[3];
					res_c.status = isat_c ? qalu_pkg::ST_SAT : qalu_pkg::ST_OK;
				end
			end
			default: res_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= vld;
		end
	end

	always_ff @(posedge clk) begin
		res_s1 <= res_c;
	end

	assign done = done_s1;
	assign res  = res_s1;

endmodule
`default_nettype wire

FILE: design/quaternion_alu_top.sv
// Result: the beat appears on res with done high after the front, step and back registers.
// Throughput: one item per cycle; busy is always low, the pipeline never stalls.
// Depth is set by the inverse divider (33 quotient bits, one per stage) after 4 front stages.
// Reset: arst_n clears all valid bits at once; no item is in flight afterwards.
`default_nettype none
module quaternion_alu_top (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  wire qalu_pkg::cmd_t   cmd,
	output logic                  busy,
	output logic                  done,
	output qalu_pkg::res_t        res
);

	localparam int LAT = 38;

	logic             vld [qalu_pkg::NSTEP + 1];
	qalu_pkg::iter_t  it  [qalu_pkg::NSTEP + 1];

	assign busy = 1'b0;

	qalu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld     (start),
		.cmd     (cmd),
		.out_vld (vld[0]),
		.out_it  (it[0])
	);

	generate
		for (genvar k = 0; k < qalu_pkg::NSTEP; k++) begin : g_step
			qalu_step #(.STEP(k)) u_step (
				.clk     (clk),
				.arst_n  (arst_n),
				.vld     (vld[k]),
				.it      (it[k]),
				.out_vld (vld[k + 1]),
				.out_it  (it[k + 1])
			);
		end
	endgenerate

	qalu_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.vld    (vld[qalu_pkg::NSTEP]),
		.it     (it[qalu_pkg::NSTEP]),
		.done   (done),
		.res    (res)
	);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##LAT done)
		else $error("accepted beat did not come out after fixed latency");

	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (res.status == qalu_pkg::ST_DIVZ) |->
		(res.r_w == 32'sd0) && (res.r_x == 32'sd0) && (res.r_y == 32'sd0) &&
		(res.r_z == 32'sd0) && (res.magnitude == 32'd0))
		else $error("divide-by-zero beat carries non-zero fields");

	a_norm_only: assert property (@(posedge clk) disable iff (!arst_n)
		done && (res.magnitude != 32'd0) |->
		(res.r_w == 32'sd0) && (res.r_x == 32'sd0) && (res.r_y == 32'sd0) &&
		(res.r_z == 32'sd0))
		else $error("magnitude beat carries a quaternion");

endmodule
`default_nettype wire

FILE: tb/tb_quaternion_alu_top.sv
`timescale 1ns / 1ps
module tb_quaternion_alu_top;

	localparam int LATENCY   = 38;
	localparam int CYCLE_CAP = 600000;

	logic clk;
	logic arst_n;
	logic start;
	qalu_pkg::cmd_t cmd;
	logic busy;
	logic done;
	qalu_pkg::res_t res;

	qalu_pkg::cmd_t pending_cmds[$];
	qalu_pkg::res_t expected_res[$];
	int   idle_pct;
	int   n_sent;
	int   n_checked;
	int   n_errors;
	int   n_sat;
	int   n_divz;
	int   cycles;

	quaternion_alu_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done),
		.res    (res)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	function automatic logic signed [31:0] clamp32(input logic signed [67:0] v, ref logic flag);
		if (v > 68'sd2147483647) begin
			flag = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		if (v < -68'sd2147483648) begin
			flag = 1'b1;
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

	// floor(sqrt(s))
	function automatic logic [31:0] floor_root(input logic [63:0] s);
		logic [31:0] root;
		logic [31:0] trial;
		root = '0;
		for (int i = 31; i >= 0; i--) begin
			trial = root | (32'd1 << i);
			if ({32'd0, trial} * {32'd0, trial} <= s)
				root = trial;
		end
		return root;
	endfunction

	function automatic logic signed [31:0] recip_part(input logic [31:0] m, input logic neg,
			input logic [63:0] sum, input logic carry, ref logic flag);
		logic [63:0] num;
		logic [63:0] q;
		logic [63:0] rem;
		num = {m, 32'd0};
		if (carry) begin
			q = num[63] ? 64'd1 : 64'd0;
		end else begin
			q = num / sum;
			rem = num % sum;
			if (rem >= sum - rem)
				q++;
		end
		if (neg) begin
			if (q > 64'd2147483648) begin
				flag = 1'b1;
				return 32'sh8000_0000;
			end
			return -q[31:0];
		end
		if (q > 64'd2147483647) begin
			flag = 1'b1;
			return 32'sh7FFF_FFFF;
		end
		return q[31:0];
	endfunction

	// Hamilton product term: round(sum / 2^16), ties toward plus infinity
	function automatic logic signed [67:0] hamilton_term(
			input logic signed [31:0] p0, input logic signed [31:0] q0, input int s0,
			input logic signed [31:0] p1, input logic signed [31:0] q1, input int s1,
			input logic signed [31:0] p2, input logic signed [31:0] q2, input int s2,
			input logic signed [31:0] p3, input logic signed [31:0] q3, input int s3);
		logic signed [67:0] acc;
		acc = 68'(p0) * 68'(q0) * s0 + 68'(p1) * 68'(q1) * s1
			+ 68'(p2) * 68'(q2) * s2 + 68'(p3) * 68'(q3) * s3;
		return (acc + 68'sd32768) >>> 16;
	endfunction

	function automatic qalu_pkg::res_t quaternion_result(input qalu_pkg::cmd_t c);
		qalu_pkg::res_t r;
		logic flag;
		logic signed [31:0] a[4];
		logic signed [31:0] b[4];
		logic signed [31:0] q[4];
		logic [31:0] m;
		logic [65:0] sum;
		logic negs;
		a = '{c.a_w, c.a_x, c.a_y, c.a_z};
		b = '{c.b_w, c.b_x, c.b_y, c.b_z};
		q = '{0, 0, 0, 0};
		flag = 1'b0;
		r = '0;
		case (c.op)
			qalu_pkg::OP_ADD: for (int i = 0; i < 4; i++)
				q[i] = clamp32(68'(a[i]) + 68'(b[i]), flag);
			qalu_pkg::OP_NEG: for (int i = 0; i < 4; i++)
				q[i] = clamp32(-68'(a[i]), flag);
			qalu_pkg::OP_MUL: begin
				q[0] = clamp32(hamilton_term(a[0], b[0], 1, a[1], b[1], -1,
					a[2], b[2], -1, a[3], b[3], -1), flag);
				q[1] = clamp32(hamilton_term(a[0], b[1], 1, a[1], b[0], 1,
					a[2], b[3], 1, a[3], b[2], -1), flag);
				q[2] = clamp32(hamilton_term(a[0], b[2], 1, a[1], b[3], -1,
					a[2], b[0], 1, a[3], b[1], 1), flag);
				q[3] = clamp32(hamilton_term(a[0], b[3], 1, a[1], b[2], 1,
					a[2], b[1], -1, a[3], b[0], 1), flag);
			end
			qalu_pkg::OP_CONJ: begin
				q[0] = a[0];
				for (int i = 1; i < 4; i++)
					q[i] = clamp32(-68'(a[i]), flag);
			end
			qalu_pkg::OP_NORM, qalu_pkg::OP_INV: begin
				sum = '0;
				for (int i = 0; i < 4; i++) begin
					m = a[i] < 0 ? -a[i] : a[i];
					sum += {34'd0, m} * {34'd0, m};
				end
				if (c.op == qalu_pkg::OP_NORM) begin
					if (sum[65:64] != 2'd0) begin
						r.magnitude = 32'hFFFF_FFFF;
						flag = 1'b1;
					end else begin
						r.magnitude = floor_root(sum[63:0]);
					end
				end else if (sum == '0) begin
					r.status = qalu_pkg::ST_DIVZ;
				end else begin
					for (int i = 0; i < 4; i++) begin
						m = a[i] < 0 ? -a[i] : a[i];
						negs = (i == 0) ? (a[i] < 0) : (a[i] > 0);
						q[i] = recip_part(m, negs, sum[63:0], sum[65:64] != 2'd0, flag);
					end
				end
			end
			default: ;
		endcase
		r.r_w = q[0];
		r.r_x = q[1];
		r.r_y = q[2];
		r.r_z = q[3];
		if (r.status == qalu_pkg::ST_OK && flag)
			r.status = qalu_pkg::ST_SAT;
		return r;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start <= 1'b0;
			cmd   <= '0;
		end else begin
			if (start && !busy) begin
				expected_res.push_back(quaternion_result(cmd));
				void'(pending_cmds.pop_front());
				n_sent++;
			end
			if (pending_cmds.size() > 0 && $urandom_range(99) >= idle_pct) begin
				start <= 1'b1;
				cmd   <= pending_cmds[0];
			end else begin
				start <= 1'b0;
			end
		end
	end

	task automatic check_field(input string name, input logic [31:0] got, input logic [31:0] want,
			ref logic bad);
		if (got !== want) begin
			bad = 1'b1;
			if (n_errors < 10)
				$display("mismatch beat %0d %s: expected %h got %h", n_checked, name, want, got);
		end
	endtask

	// monitor
	always @(posedge clk) begin
		qalu_pkg::res_t want;
		logic bad;
		cycles++;
		if (arst_n && done) begin
			if (expected_res.size() == 0) begin
				if (n_errors < 10)
					$display("unexpected result beat %h", res);
				n_errors++;
			end else begin
				want = expected_res.pop_front();
				bad = 1'b0;
				check_field("r_w", res.r_w, want.r_w, bad);
				check_field("r_x", res.r_x, want.r_x, bad);
				check_field("r_y", res.r_y, want.r_y, bad);
				check_field("r_z", res.r_z, want.r_z, bad);
				check_field("magnitude", res.magnitude, want.magnitude, bad);
				check_field("status", 32'(res.status), 32'(want.status), bad);
				if (bad)
					n_errors++;
				if (want.status == qalu_pkg::ST_SAT)
					n_sat++;
				if (want.status == qalu_pkg::ST_DIVZ)
					n_divz++;
				n_checked++;
			end
		end
		if (cycles > CYCLE_CAP) begin
			$display("timeout after %0d cycles", cycles);
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic signed [31:0] pick_comp();
		case ($urandom_range(9))
			0: return 32'sh8000_0000;
			1: return 32'sh7FFF_FFFF;
			2, 3: return $signed($urandom_range(262143)) - 32'sd131072;
			4: return $signed($urandom_range(15)) - 32'sd8;
			default: return $urandom;
		endcase
	endfunction

	task automatic push_cmd(input logic [2:0] op, input logic signed [31:0] aw,
			input logic signed [31:0] ax, input logic signed [31:0] ay, input logic signed [31:0] az,
			input logic signed [31:0] bw, input logic signed [31:0] bx,
			input logic signed [31:0] by, input logic signed [31:0] bz);
		qalu_pkg::cmd_t c;
		c = '{op, aw, ax, ay, az, bw, bx, by, bz};
		pending_cmds.push_back(c);
	endtask

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || expected_res.size() > 0)
			@(posedge clk);
	endtask

	localparam logic signed [31:0] MAXV = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] MINV = 32'sh8000_0000;
	localparam logic signed [31:0] ONE  = 32'sh0001_0000;

	initial begin
		qalu_pkg::cmd_t c;
		int pcts[4];
		pcts = '{0, 81, 21, 0};
		arst_n = 1'b0;
		idle_pct = 0;
		n_sent = 0;
		n_checked = 0;
		n_errors = 0;
		n_sat = 0;
		n_divz = 0;
		cycles = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		push_cmd(qalu_pkg::OP_ADD, MAXV, MINV, 1, -1, MAXV, MINV, 0, 0);
		push_cmd(qalu_pkg::OP_ADD, MAXV, MINV, MAXV, MINV, -1, 1, 1, -1);
		push_cmd(qalu_pkg::OP_NEG, MINV, MAXV, 0, -1, 0, 0, 0, 0);
		push_cmd(qalu_pkg::OP_NEG, 5, -5, ONE, -ONE, MINV, MINV, MINV, MINV);
		push_cmd(qalu_pkg::OP_MUL, ONE, 0, 0, 0, 3, -4, 5, -6);
		push_cmd(qalu_pkg::OP_MUL, 0, ONE, 0, 0, 0, ONE, 0, 0);
		push_cmd(qalu_pkg::OP_MUL, MAXV, MAXV, MAXV, MAXV, MAXV, MINV, MAXV, MINV);
		push_cmd(qalu_pkg::OP_MUL, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV);
		push_cmd(qalu_pkg::OP_MUL, 1, 1, 0, 0, 32768, -32768, 0, 0);
		push_cmd(qalu_pkg::OP_CONJ, MINV, MINV, MAXV, 7, 0, 0, 0, 0);
		push_cmd(qalu_pkg::OP_NORM, MINV, MINV, MINV, MINV, 0, 0, 0, 0);
		push_cmd(qalu_pkg::OP_NORM, MAXV, MAXV, MAXV, MAXV, 0, 0, 0, 0);
		push_cmd(qalu_pkg::OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(qalu_pkg::OP_NORM, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0, 0);
		push_cmd(qalu_pkg::OP_INV, 0, 0, 0, 0, MAXV, 1, 1, 1);
		push_cmd(qalu_pkg::OP_INV, 1, 0, 0, 0, 0, 0, 0, 0);
		push_cmd(qalu_pkg::OP_INV, -1, 1, -1, 1, 0, 0, 0, 0);
		push_cmd(qalu_pkg::OP_INV, ONE, ONE, -ONE, ONE, 0, 0, 0, 0);
		push_cmd(qalu_pkg::OP_INV, MINV, MINV, MINV, MINV, 0, 0, 0, 0);
		push_cmd(qalu_pkg::OP_INV, MAXV, MINV, 0, 0, 0, 0, 0, 0);
		push_cmd(3'd6, 1, 2, 3, 4, 5, 6, 7, 8);
		push_cmd(3'd7, MINV, MAXV, -1, 1, MINV, MAXV, -1, 1);
		wait_drained();

		foreach (pcts[p]) begin
			idle_pct = pcts[p];
			for (int n = 0; n < 270; n++) begin
				c.op = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 6)) : 3'($urandom_range(5));
				c.a_w = pick_comp();
				c.a_x = pick_comp();
				c.a_y = pick_comp();
				c.a_z = pick_comp();
				c.b_w = pick_comp();
				c.b_x = pick_comp();
				c.b_y = pick_comp();
				c.b_z = pick_comp();
				pending_cmds.push_back(c);
			end
			wait_drained();
		end
		repeat (LATENCY + 20) @(posedge clk);

		$display("%0d commands sent, %0d results checked over four idling phases", n_sent, n_checked);
		$display("%0d saturated and %0d zero-inverse results seen, %0d mismatches",
			n_sat, n_divz, n_errors);
		if (n_errors == 0 && expected_res.size() == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
